// ----- design/ipv4rx_pkg.sv -----
// Shared types and constants for the IPv4 receive header checker.
// Used by the parse, judge and top-level modules; no dependencies.
package ipv4rx_pkg;

   localparam int LenW = 16;

   localparam logic [3:0] VerdictIcmp     = 4'd0;
   localparam logic [3:0] VerdictTcp      = 4'd1;
   localparam logic [3:0] VerdictUdp      = 4'd2;
   localparam logic [3:0] VerdictOther    = 4'd3;
   localparam logic [3:0] VerdictShort    = 4'd4;
   localparam logic [3:0] VerdictVersion  = 4'd5;
   localparam logic [3:0] VerdictIhl      = 4'd6;
   localparam logic [3:0] VerdictChecksum = 4'd7;
   localparam logic [3:0] VerdictTotalLen = 4'd8;
   localparam logic [3:0] VerdictNotOurs  = 4'd9;
   localparam logic [3:0] VerdictTooLong  = 4'd10;

   localparam logic [7:0]  ProtoIcmp = 8'd1;
   localparam logic [7:0]  ProtoTcp  = 8'd6;
   localparam logic [7:0]  ProtoUdp  = 8'd17;
   localparam logic [3:0]  IpVersion = 4'd4;
   localparam logic [5:0]  HdrMin    = 6'd20;
   localparam logic [15:0] SumGood   = 16'hFFFF;
   localparam logic [31:0] BcastAddr = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [LenW-1:0] byte_count;
      logic [3:0]      version;
      logic [3:0]      ihl;
      logic [15:0]     sum;
      logic [15:0]     total_length;
      logic [7:0]      protocol;
      logic [31:0]     source;
      logic [31:0]     destination;
      logic            overflow;
   } pkt_snap_type;

endpackage

// ----- design/ipv4rx_parse.sv -----
// Per-byte header capture and one's-complement sum for the IPv4 checker.
// Hands a snapshot of the packet state to the judge on the final byte.
// Depends on ipv4rx_pkg.
module ipv4rx_parse
   import ipv4rx_pkg::*;
#(
   parameter int MAX_BYTES = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         take,
   input  logic [7:0]   in_byte,
   input  logic         last,
   input  logic         snap_taken,
   output logic         snap_valid,
   output pkt_snap_type snap
);

   localparam int CntW = $clog2(MAX_BYTES + 1);
   localparam logic [CntW-1:0] MaxCount = CntW'(MAX_BYTES);

   logic [CntW-1:0] count_ff, count_in;
   logic [3:0]      version_ff, version_in;
   logic [3:0]      ihl_ff, ihl_in;
   logic [15:0]     sum_ff, sum_in;
   logic [7:0]      high_ff, high_in;
   logic [15:0]     total_ff, total_in;
   logic [7:0]      proto_ff, proto_in;
   logic [31:0]     src_ff, src_in;
   logic [31:0]     dst_ff, dst_in;
   logic            ovf_ff, ovf_in;
   logic            snap_valid_ff, snap_valid_in;
   pkt_snap_type    snap_ff, snap_in;

   logic [5:0]      hb;
   logic [16:0]     sum_wide;

   always_comb begin
      version_in = version_ff;
      ihl_in     = ihl_ff;
      sum_in     = sum_ff;
      high_in    = high_ff;
      total_in   = total_ff;
      proto_in   = proto_ff;
      src_in     = src_ff;
      dst_in     = dst_ff;
      ovf_in     = ovf_ff;
      count_in   = count_ff;
      hb         = 6'd0;
      sum_wide   = 17'd0;
      if (count_ff == MaxCount) begin
         ovf_in = 1'b1;
      end else begin
         count_in = count_ff + 1'b1;
         if (count_ff == CntW'(0)) begin
            version_in = in_byte[7:4];
            ihl_in     = in_byte[3:0];
         end else if (count_ff == CntW'(2) || count_ff == CntW'(3)) begin
            total_in = {total_ff[7:0], in_byte};
         end else if (count_ff == CntW'(9)) begin
            proto_in = in_byte;
         end else if (count_ff >= CntW'(12) && count_ff < CntW'(16)) begin
            src_in = {src_ff[23:0], in_byte};
         end else if (count_ff >= CntW'(16) && count_ff < CntW'(20)) begin
            dst_in = {dst_ff[23:0], in_byte};
         end
         hb = {ihl_in, 2'b00};
         if (count_ff < CntW'(hb)) begin
            if (!count_ff[0]) begin
               high_in = in_byte;
            end else begin
               sum_wide = {1'b0, sum_ff} + {1'b0, high_ff, in_byte};
               sum_in   = sum_wide[15:0] + {15'd0, sum_wide[16]};
            end
         end
      end

      snap_in.byte_count   = LenW'(count_in);
      snap_in.version      = version_in;
      snap_in.ihl          = ihl_in;
      snap_in.sum          = sum_in;
      snap_in.total_length = total_in;
      snap_in.protocol     = proto_in;
      snap_in.source       = src_in;
      snap_in.destination  = dst_in;
      snap_in.overflow     = ovf_in;

      snap_valid_in = snap_valid_ff;
      if (take && last) begin
         snap_valid_in = 1'b1;
      end else if (snap_taken) begin
         snap_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         version_ff    <= '0;
         ihl_ff        <= '0;
         sum_ff        <= '0;
         high_ff       <= '0;
         total_ff      <= '0;
         proto_ff      <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
         ovf_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (take && last) begin
            count_ff   <= '0;
            version_ff <= '0;
            ihl_ff     <= '0;
            sum_ff     <= '0;
            high_ff    <= '0;
            total_ff   <= '0;
            proto_ff   <= '0;
            src_ff     <= '0;
            dst_ff     <= '0;
            ovf_ff     <= 1'b0;
         end else if (take) begin
            count_ff   <= count_in;
            version_ff <= version_in;
            ihl_ff     <= ihl_in;
            sum_ff     <= sum_in;
            high_ff    <= high_in;
            total_ff   <= total_in;
            proto_ff   <= proto_in;
            src_ff     <= src_in;
            dst_ff     <= dst_in;
            ovf_ff     <= ovf_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && last) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ----- design/ipv4rx_judge.sv -----
// Verdict logic and result register for the IPv4 checker.
// Judges a packet snapshot against the own address. Depends on ipv4rx_pkg.
module ipv4rx_judge
   import ipv4rx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         snap_valid,
   input  pkt_snap_type snap,
   input  logic [31:0]  own_address,
   input  logic         out_stall,
   output logic         out_ready,
   output logic         out_valid,
   output logic [3:0]   verdict,
   output logic [31:0]  source_address,
   output logic [7:0]   protocol_number,
   output logic [5:0]   header_bytes,
   output logic [15:0]  payload_length
);

   logic        valid_ff, valid_in;
   logic [3:0]  verdict_ff, verdict_in;
   logic [31:0] src_ff, src_in;
   logic [7:0]  proto_ff;
   logic [5:0]  hb_ff, hb;
   logic [15:0] plen_ff, plen_in;
   logic [15:0] hb_wide;

   assign out_ready = !valid_ff || !out_stall;
   assign hb        = {snap.ihl, 2'b00};
   assign hb_wide   = {10'd0, hb};

   always_comb begin
      src_in  = '0;
      plen_in = '0;
      if (snap.overflow) begin
         verdict_in = VerdictTooLong;
      end else if (snap.byte_count < {10'd0, HdrMin}) begin
         verdict_in = VerdictShort;
      end else if (snap.version != IpVersion) begin
         verdict_in = VerdictVersion;
      end else if (hb < HdrMin || hb_wide > snap.byte_count) begin
         verdict_in = VerdictIhl;
      end else if (snap.sum != SumGood) begin
         verdict_in = VerdictChecksum;
      end else if (snap.total_length > snap.byte_count || snap.total_length < hb_wide) begin
         verdict_in = VerdictTotalLen;
      end else if (snap.destination != own_address && snap.destination != BcastAddr) begin
         verdict_in = VerdictNotOurs;
      end else begin
         src_in  = snap.source;
         plen_in = snap.total_length - hb_wide;
         if (snap.protocol == ProtoIcmp) begin
            verdict_in = VerdictIcmp;
         end else if (snap.protocol == ProtoTcp) begin
            verdict_in = VerdictTcp;
         end else if (snap.protocol == ProtoUdp) begin
            verdict_in = VerdictUdp;
         end else begin
            verdict_in = VerdictOther;
         end
      end
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = snap_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && snap_valid) begin
         verdict_ff <= verdict_in;
         src_ff     <= src_in;
         proto_ff   <= snap.protocol;
         hb_ff      <= hb;
         plen_ff    <= plen_in;
      end
   end

   assign out_valid       = valid_ff;
   assign verdict         = verdict_ff;
   assign source_address  = src_ff;
   assign protocol_number = proto_ff;
   assign header_bytes    = hb_ff;
   assign payload_length  = plen_ff;

endmodule

// ----- design/ipv4_receive_header_checker_unit.sv -----
// IPv4 receive header checker, top level: one byte per transfer in, one verdict per packet out.
// A final byte's verdict passes through the snapshot register and then the result register
// on its way to the outputs; while the result register is stalled, it waits in the snapshot.
// Throughput: one byte per cycle; the byte path stalls only while the snapshot and
// result registers both hold unaccepted verdicts.
// Reset (synchronous, active high) clears packet state, own address and all valid flags.
// Depends on ipv4rx_pkg, ipv4rx_parse and ipv4rx_judge.
module ipv4_receive_header_checker_unit
   import ipv4rx_pkg::*;
#(
   parameter int MAX_BYTES = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_verdict,
   output logic [31:0] rsp_source_address,
   output logic [7:0]  rsp_protocol_number,
   output logic [5:0]  rsp_header_bytes,
   output logic [15:0] rsp_payload_length,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_own_address
);

   logic [31:0]  own_ff;
   logic         take;
   logic         snap_valid;
   logic         out_ready;
   pkt_snap_type snap;

   assign csr_ready = 1'b1;
   assign req_stall = snap_valid && !out_ready;
   assign take      = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         own_ff <= csr_own_address;
      end
   end

   ipv4rx_parse #(
      .MAX_BYTES(MAX_BYTES)
   ) u_parse (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .in_byte    (req_in_byte),
      .last       (req_last),
      .snap_taken (snap_valid && out_ready),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   ipv4rx_judge u_judge (
      .clock           (clock),
      .reset           (reset),
      .snap_valid      (snap_valid),
      .snap            (snap),
      .own_address     (own_ff),
      .out_stall       (rsp_stall),
      .out_ready       (out_ready),
      .out_valid       (rsp_valid),
      .verdict         (rsp_verdict),
      .source_address  (rsp_source_address),
      .protocol_number (rsp_protocol_number),
      .header_bytes    (rsp_header_bytes),
      .payload_length  (rsp_payload_length)
   );

`ifndef ASSERT_OFF
   a_final_loads_snap: assert property (@(posedge clock) disable iff (reset)
      take && req_last |=> snap_valid)
      else $error("final byte did not load snapshot");

   a_reject_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict >= VerdictShort |->
         rsp_source_address == 32'd0 && rsp_payload_length == 16'd0)
      else $error("rejected packet carries address or length");

   a_deliver_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_verdict <= VerdictOther |-> rsp_header_bytes >= HdrMin)
      else $error("delivered packet with short header");
`endif

endmodule
